/* rtl/chlcd_pkg.sv */
// ----------------------------------------------------------------------------
// chlcd_pkg: shared types, constants and microcode for the LCD text engine
// Holds the control word layout, the program ROM, the command entry table
// and the constant tables for line bases, init bytes and powers of ten.
// ----------------------------------------------------------------------------
`default_nettype none

package chlcd_pkg;

    // command codes of an input transaction
    localparam logic [2:0] CMD_CHAR    = 3'd0;
    localparam logic [2:0] CMD_CURSOR  = 3'd1;
    localparam logic [2:0] CMD_CLEAR   = 3'd2;
    localparam logic [2:0] CMD_DECIMAL = 3'd3;
    localparam logic [2:0] CMD_HEX     = 3'd4;
    localparam logic [2:0] CMD_BINARY  = 3'd5;
    localparam logic [2:0] CMD_INIT    = 3'd6;

    // LCD bytes and settle waits
    localparam logic [7:0]  LCD_CLEAR   = 8'h01;
    localparam logic [7:0]  LCD_HOME    = 8'h02;
    localparam logic [11:0] WAIT_CHAR   = 12'd2400;
    localparam logic [11:0] WAIT_CURSOR = 12'd600;
    localparam logic [11:0] WAIT_CLEAR  = 12'd800;
    localparam logic [11:0] WAIT_INIT   = 12'd1800;
    localparam int          INIT_LEN    = 9;
    localparam int          DEC_DIGITS  = 10;

    // ASCII codes used by the number formatters
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_ONE   = 8'h31;
    localparam logic [7:0] ASCII_ALPHA = 8'h37;  // 'A' - 10
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] ASCII_X     = 8'h78;
    localparam logic [7:0] ASCII_B     = 8'h62;

    // one LCD bus write
    typedef struct packed {
        logic        rs;
        logic [7:0]  bus_byte;
        logic [11:0] settle_wait;
        logic        last;
    } wr_t;

    // control word fields
    typedef enum logic [2:0] {
        BS_CHAR, BS_CURSOR, BS_CLEAR, BS_HOME, BS_INIT
    } bsel_t;

    typedef enum logic [1:0] {
        WS_CHAR, WS_CURSOR, WS_CLEAR, WS_INIT
    } wsel_t;

    typedef enum logic [1:0] {
        LS_ZERO, LS_ONE, LS_FINAL, LS_INIT
    } lsel_t;

    typedef enum logic [4:0] {
        A_NONE, A_FINAL_SET, A_SETPOS, A_HOMEPOS, A_DEC_SETUP, A_DIGIT,
        A_FINAL_DEC, A_STARTED, A_NEXT_DIGIT, A_LOAD_CNT, A_FINAL_CNT,
        A_SHL4, A_SHL1, A_INIT_SETUP, A_INC_CNT, A_NEXTROW, A_INCCOL
    } act_t;

    typedef enum logic [2:0] {
        CS_INPUT, CS_MINUS, CS_ZERO, CS_X, CS_B, CS_DEC, CS_HEX, CS_BIT
    } csel_t;

    typedef enum logic [2:0] {
        N_SEQ, N_JUMP, N_CALL, N_RET, N_DISPATCH, N_IDLE
    } nxt_t;

    typedef enum logic [2:0] {
        K_ALWAYS, K_NOT_FULL, K_NOT_LASTROW, K_POSITIVE, K_GE, K_SKIP,
        K_MORE, K_NOT_INIT_END
    } cond_t;

    localparam int PC_W = 6;

    typedef struct packed {
        logic            emit;
        logic            rs;
        bsel_t           bsel;
        wsel_t           wsel;
        lsel_t           lsel;
        act_t            act;
        csel_t           csel;
        nxt_t            nxt;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } cw_t;

    // program labels
    localparam logic [PC_W-1:0] PC_IDLE       = 6'd0;
    localparam logic [PC_W-1:0] PC_CHAR       = 6'd1;
    localparam logic [PC_W-1:0] PC_CURSOR     = 6'd3;
    localparam logic [PC_W-1:0] PC_CLEAR      = 6'd4;
    localparam logic [PC_W-1:0] PC_DEC        = 6'd6;
    localparam logic [PC_W-1:0] PC_DEC_DIGIT  = 6'd8;
    localparam logic [PC_W-1:0] PC_DEC_NEXT   = 6'd11;
    localparam logic [PC_W-1:0] PC_HEX        = 6'd13;
    localparam logic [PC_W-1:0] PC_HEX_LOOP   = 6'd15;
    localparam logic [PC_W-1:0] PC_BIN        = 6'd19;
    localparam logic [PC_W-1:0] PC_BIN_LOOP   = 6'd21;
    localparam logic [PC_W-1:0] PC_INIT       = 6'd25;
    localparam logic [PC_W-1:0] PC_INIT_LOOP  = 6'd26;
    localparam logic [PC_W-1:0] PC_PUT        = 6'd28;
    localparam logic [PC_W-1:0] PC_PUT_CURSOR = 6'd32;
    localparam logic [PC_W-1:0] PC_PUT_CHAR   = 6'd33;

    // DDRAM address command for the start of each line
    function automatic logic [7:0] line_base(input logic [1:0] y);
        logic [7:0] b;
        case (y)
            2'd0:    b = 8'h80;
            2'd1:    b = 8'hC0;
            2'd2:    b = 8'h90;
            default: b = 8'hD0;
        endcase
        return b;
    endfunction

    // power-up command bytes
    function automatic logic [7:0] init_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h30;
            4'd1:    b = 8'h30;
            4'd2:    b = 8'h30;
            4'd3:    b = 8'h38;
            4'd4:    b = 8'h08;
            4'd5:    b = 8'h01;
            4'd6:    b = 8'h06;
            4'd7:    b = 8'h0C;
            default: b = 8'h80;
        endcase
        return b;
    endfunction

    // decimal place weights
    function automatic logic [31:0] pow10(input logic [3:0] idx);
        logic [31:0] p;
        case (idx)
            4'd0:    p = 32'd1;
            4'd1:    p = 32'd10;
            4'd2:    p = 32'd100;
            4'd3:    p = 32'd1000;
            4'd4:    p = 32'd10000;
            4'd5:    p = 32'd100000;
            4'd6:    p = 32'd1000000;
            4'd7:    p = 32'd10000000;
            4'd8:    p = 32'd100000000;
            default: p = 32'd1000000000;
        endcase
        return p;
    endfunction

    // first program step of each command
    function automatic logic [PC_W-1:0] entry_pc(input logic [2:0] cmd);
        logic [PC_W-1:0] pc;
        case (cmd)
            CMD_CHAR:    pc = PC_CHAR;
            CMD_CURSOR:  pc = PC_CURSOR;
            CMD_CLEAR:   pc = PC_CLEAR;
            CMD_DECIMAL: pc = PC_DEC;
            CMD_HEX:     pc = PC_HEX;
            CMD_BINARY:  pc = PC_BIN;
            CMD_INIT:    pc = PC_INIT;
            default:     pc = PC_IDLE;
        endcase
        return pc;
    endfunction

    // program ROM
    function automatic cw_t ucode(input logic [PC_W-1:0] pc);
        cw_t cw;
        cw.emit   = 1'b0;
        cw.rs     = 1'b0;
        cw.bsel   = BS_CHAR;
        cw.wsel   = WS_CHAR;
        cw.lsel   = LS_ZERO;
        cw.act    = A_NONE;
        cw.csel   = CS_INPUT;
        cw.nxt    = N_SEQ;
        cw.cond   = K_ALWAYS;
        cw.target = PC_IDLE;
        case (pc)
            // wait for a transaction and branch on its command
            PC_IDLE: begin
                cw.nxt = N_DISPATCH;
            end
            // single character
            PC_CHAR: begin
                cw.act = A_FINAL_SET; cw.nxt = N_CALL; cw.target = PC_PUT;
                cw.csel = CS_INPUT;
            end
            PC_CHAR + 6'd1: begin
                cw.nxt = N_IDLE;
            end
            // set cursor
            PC_CURSOR: begin
                cw.emit = 1'b1; cw.bsel = BS_CURSOR; cw.wsel = WS_CURSOR;
                cw.lsel = LS_ONE; cw.act = A_SETPOS; cw.nxt = N_IDLE;
            end
            // clear screen
            PC_CLEAR: begin
                cw.emit = 1'b1; cw.bsel = BS_CLEAR; cw.wsel = WS_CLEAR;
            end
            PC_CLEAR + 6'd1: begin
                cw.emit = 1'b1; cw.bsel = BS_HOME; cw.wsel = WS_CLEAR;
                cw.lsel = LS_ONE; cw.act = A_HOMEPOS; cw.nxt = N_IDLE;
            end
            // signed decimal
            PC_DEC: begin
                cw.act = A_DEC_SETUP; cw.nxt = N_JUMP; cw.cond = K_POSITIVE;
                cw.target = PC_DEC_DIGIT;
            end
            PC_DEC + 6'd1: begin
                cw.nxt = N_CALL; cw.target = PC_PUT; cw.csel = CS_MINUS;
            end
            PC_DEC_DIGIT: begin
                cw.act = A_DIGIT; cw.nxt = N_JUMP; cw.cond = K_GE;
                cw.target = PC_DEC_DIGIT;
            end
            PC_DEC_DIGIT + 6'd1: begin
                cw.act = A_FINAL_DEC; cw.nxt = N_JUMP; cw.cond = K_SKIP;
                cw.target = PC_DEC_NEXT;
            end
            PC_DEC_DIGIT + 6'd2: begin
                cw.act = A_STARTED; cw.nxt = N_CALL; cw.target = PC_PUT;
                cw.csel = CS_DEC;
            end
            PC_DEC_NEXT: begin
                cw.act = A_NEXT_DIGIT; cw.nxt = N_JUMP; cw.cond = K_MORE;
                cw.target = PC_DEC_DIGIT;
            end
            PC_DEC_NEXT + 6'd1: begin
                cw.nxt = N_IDLE;
            end
            // hex word with prefix
            PC_HEX: begin
                cw.act = A_LOAD_CNT; cw.nxt = N_CALL; cw.target = PC_PUT;
                cw.csel = CS_ZERO;
            end
            PC_HEX + 6'd1: begin
                cw.nxt = N_CALL; cw.target = PC_PUT; cw.csel = CS_X;
            end
            PC_HEX_LOOP: begin
                cw.act = A_FINAL_CNT;
            end
            PC_HEX_LOOP + 6'd1: begin
                cw.nxt = N_CALL; cw.target = PC_PUT; cw.csel = CS_HEX;
            end
            PC_HEX_LOOP + 6'd2: begin
                cw.act = A_SHL4; cw.nxt = N_JUMP; cw.cond = K_MORE;
                cw.target = PC_HEX_LOOP;
            end
            PC_HEX_LOOP + 6'd3: begin
                cw.nxt = N_IDLE;
            end
            // binary byte with prefix
            PC_BIN: begin
                cw.act = A_LOAD_CNT; cw.nxt = N_CALL; cw.target = PC_PUT;
                cw.csel = CS_ZERO;
            end
            PC_BIN + 6'd1: begin
                cw.nxt = N_CALL; cw.target = PC_PUT; cw.csel = CS_B;
            end
            PC_BIN_LOOP: begin
                cw.act = A_FINAL_CNT;
            end
            PC_BIN_LOOP + 6'd1: begin
                cw.nxt = N_CALL; cw.target = PC_PUT; cw.csel = CS_BIT;
            end
            PC_BIN_LOOP + 6'd2: begin
                cw.act = A_SHL1; cw.nxt = N_JUMP; cw.cond = K_MORE;
                cw.target = PC_BIN_LOOP;
            end
            PC_BIN_LOOP + 6'd3: begin
                cw.nxt = N_IDLE;
            end
            // power-up sequence
            PC_INIT: begin
                cw.act = A_INIT_SETUP;
            end
            PC_INIT_LOOP: begin
                cw.emit = 1'b1; cw.bsel = BS_INIT; cw.wsel = WS_INIT;
                cw.lsel = LS_INIT; cw.act = A_INC_CNT; cw.nxt = N_JUMP;
                cw.cond = K_NOT_INIT_END; cw.target = PC_INIT_LOOP;
            end
            PC_INIT_LOOP + 6'd1: begin
                cw.nxt = N_IDLE;
            end
            // put-character subroutine with line wrap
            PC_PUT: begin
                cw.nxt = N_JUMP; cw.cond = K_NOT_FULL; cw.target = PC_PUT_CHAR;
            end
            PC_PUT + 6'd1: begin
                cw.act = A_NEXTROW; cw.nxt = N_JUMP; cw.cond = K_NOT_LASTROW;
                cw.target = PC_PUT_CURSOR;
            end
            PC_PUT + 6'd2: begin
                cw.emit = 1'b1; cw.bsel = BS_CLEAR; cw.wsel = WS_CLEAR;
            end
            PC_PUT + 6'd3: begin
                cw.emit = 1'b1; cw.bsel = BS_HOME; cw.wsel = WS_CLEAR;
            end
            PC_PUT_CURSOR: begin
                cw.emit = 1'b1; cw.bsel = BS_CURSOR; cw.wsel = WS_CURSOR;
                cw.act = A_SETPOS;
            end
            PC_PUT_CHAR: begin
                cw.emit = 1'b1; cw.rs = 1'b1; cw.bsel = BS_CHAR;
                cw.wsel = WS_CHAR; cw.lsel = LS_FINAL; cw.act = A_INCCOL;
                cw.nxt = N_RET;
            end
            default: begin
                cw.nxt = N_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

/* rtl/char_lcd_text_engine.sv */
// ----------------------------------------------------------------------------
// char_lcd_text_engine: text front end for a character LCD
// Microcoded sequencer that turns character, cursor, clear, number and
// init commands into LCD bus writes, tracking cursor column and row.
// ----------------------------------------------------------------------------
// A bus write is registered and presented in the cycle after its microcode step.
// Throughput: one control word per cycle; a write stalled by the sink holds its step,
//   and the dispatch step waits for a valid input. Decimal digits come from repeated
//   subtraction of the digit weights; a line wrap adds a cursor write, a screen wrap
//   a clear, a home and a cursor write.
// Reset: synchronous, active low; cursor homes and the result register empties.
`default_nettype none

module char_lcd_text_engine #(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_cmd,
    input  wire logic [7:0]         s_char_code,
    input  wire logic signed [31:0] s_value,
    input  wire logic [3:0]         s_column,
    input  wire logic [1:0]         s_row,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_reg_select,
    output logic [7:0]              m_bus_byte,
    output logic [11:0]             m_settle_wait,
    output logic                    m_last
);

    localparam int CNT_W = $clog2(COLUMNS + 1);
    localparam int X_W   = $clog2(COLUMNS);
    localparam int PC_W  = chlcd_pkg::PC_W;

    localparam logic [CNT_W-1:0] COLS_C   = CNT_W'(COLUMNS);
    localparam logic [X_W-1:0]   X_MAX    = X_W'(COLUMNS - 1);
    localparam logic [1:0]       ROW_LAST = 2'(ROWS - 1);
    localparam logic [2:0]       ROWS_C   = 3'(ROWS);
    localparam logic [3:0]       INIT_END = 4'(chlcd_pkg::INIT_LEN - 1);
    localparam logic [3:0]       DIG_TOP  = 4'(chlcd_pkg::DEC_DIGITS - 1);

    // sequencer
    logic [PC_W-1:0] pc_reg, pc_next;
    logic [PC_W-1:0] ret_reg, ret_next;
    chlcd_pkg::cw_t  cw;
    logic            cond_true;
    logic            fire;
    logic            accept;

    // datapath
    logic [7:0]       char_reg, char_next;
    logic [31:0]      val_reg, val_next;
    logic [X_W-1:0]   x_reg, x_next;
    logic [1:0]       y_reg, y_next;
    logic [CNT_W-1:0] col_count_reg, col_count_next;
    logic [1:0]       row_reg, row_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [3:0]       digit_reg, digit_next;
    logic             started_reg, started_next;
    logic             final_reg, final_next;
    logic [7:0]       pch_reg, pch_next;

    logic [31:0]      weight;
    logic             ge;
    logic             line_full;
    logic [3:0]       nibble;
    logic [7:0]       csel_byte;
    logic [X_W-1:0]   x_sat;
    logic [1:0]       y_sat;

    // output side
    logic             out_free;
    logic             out_load;
    chlcd_pkg::wr_t   wr_req;

    assign cw = chlcd_pkg::ucode(pc_reg);

    // datapath status
    assign weight    = chlcd_pkg::pow10(cnt_reg);
    assign ge        = val_reg >= weight;
    assign line_full = col_count_reg >= COLS_C;
    assign nibble    = val_reg[31:28];

    // saturate cursor target at accept
    assign x_sat = (CNT_W'(s_column) >= COLS_C) ? X_MAX : X_W'(s_column);
    assign y_sat = ({1'b0, s_row} >= ROWS_C) ? ROW_LAST : s_row;

    // jump condition
    always_comb begin
        case (cw.cond)
            chlcd_pkg::K_ALWAYS:       cond_true = 1'b1;
            chlcd_pkg::K_NOT_FULL:     cond_true = !line_full;
            chlcd_pkg::K_NOT_LASTROW:  cond_true = row_reg != ROW_LAST;
            chlcd_pkg::K_POSITIVE:     cond_true = !val_reg[31];
            chlcd_pkg::K_GE:           cond_true = ge;
            chlcd_pkg::K_SKIP:         cond_true = (digit_reg == 4'd0) && !started_reg &&
                                                   (cnt_reg != 4'd0);
            chlcd_pkg::K_MORE:         cond_true = cnt_reg != 4'd0;
            chlcd_pkg::K_NOT_INIT_END: cond_true = cnt_reg != INIT_END;
            default:                   cond_true = 1'b0;
        endcase
    end

    // step handshake: hold on a full result register or an empty input
    assign s_ready  = cw.nxt == chlcd_pkg::N_DISPATCH;
    assign accept   = s_valid && s_ready;
    assign fire     = !(cw.emit && !out_free) && !(s_ready && !s_valid);
    assign out_load = fire && cw.emit;

    // next step
    always_comb begin
        pc_next  = pc_reg;
        ret_next = ret_reg;
        if (fire) begin
            case (cw.nxt)
                chlcd_pkg::N_SEQ:      pc_next = pc_reg + 1'b1;
                chlcd_pkg::N_JUMP:     pc_next = cond_true ? cw.target : pc_reg + 1'b1;
                chlcd_pkg::N_CALL: begin
                    pc_next  = cw.target;
                    ret_next = pc_reg + 1'b1;
                end
                chlcd_pkg::N_RET:      pc_next = ret_reg;
                chlcd_pkg::N_DISPATCH: pc_next = chlcd_pkg::entry_pc(s_cmd);
                chlcd_pkg::N_IDLE:     pc_next = chlcd_pkg::PC_IDLE;
                default:               pc_next = chlcd_pkg::PC_IDLE;
            endcase
        end
    end

    // character loaded for the put subroutine
    always_comb begin
        case (cw.csel)
            chlcd_pkg::CS_INPUT: csel_byte = char_reg;
            chlcd_pkg::CS_MINUS: csel_byte = chlcd_pkg::ASCII_MINUS;
            chlcd_pkg::CS_ZERO:  csel_byte = chlcd_pkg::ASCII_ZERO;
            chlcd_pkg::CS_X:     csel_byte = chlcd_pkg::ASCII_X;
            chlcd_pkg::CS_B:     csel_byte = chlcd_pkg::ASCII_B;
            chlcd_pkg::CS_DEC:   csel_byte = chlcd_pkg::ASCII_ZERO + {4'd0, digit_reg};
            chlcd_pkg::CS_HEX:   csel_byte = (nibble < 4'd10) ?
                                             chlcd_pkg::ASCII_ZERO + {4'd0, nibble} :
                                             chlcd_pkg::ASCII_ALPHA + {4'd0, nibble};
            chlcd_pkg::CS_BIT:   csel_byte = val_reg[7] ? chlcd_pkg::ASCII_ONE :
                                                          chlcd_pkg::ASCII_ZERO;
            default:             csel_byte = char_reg;
        endcase
    end

    // datapath actions
    always_comb begin
        char_next      = char_reg;
        val_next       = val_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        col_count_next = col_count_reg;
        row_next       = row_reg;
        cnt_next       = cnt_reg;
        digit_next     = digit_reg;
        started_next   = started_reg;
        final_next     = final_reg;
        pch_next       = pch_reg;
        if (accept) begin
            char_next = s_char_code;
            val_next  = s_value;
            x_next    = x_sat;
            y_next    = y_sat;
        end
        if (fire) begin
            if (cw.nxt == chlcd_pkg::N_CALL) begin
                pch_next = csel_byte;
            end
            case (cw.act)
                chlcd_pkg::A_NONE: begin
                end
                chlcd_pkg::A_FINAL_SET: final_next = 1'b1;
                chlcd_pkg::A_SETPOS: begin
                    col_count_next = CNT_W'(x_reg);
                    row_next       = y_reg;
                end
                chlcd_pkg::A_HOMEPOS: begin
                    col_count_next = '0;
                    row_next       = 2'd0;
                end
                chlcd_pkg::A_DEC_SETUP: begin
                    val_next     = val_reg[31] ? (~val_reg + 32'd1) : val_reg;
                    cnt_next     = DIG_TOP;
                    digit_next   = 4'd0;
                    started_next = 1'b0;
                    final_next   = 1'b0;
                end
                chlcd_pkg::A_DIGIT: begin
                    if (ge) begin
                        val_next   = val_reg - weight;
                        digit_next = digit_reg + 4'd1;
                    end
                end
                chlcd_pkg::A_FINAL_DEC: final_next = cnt_reg == 4'd0;
                chlcd_pkg::A_STARTED:   started_next = 1'b1;
                chlcd_pkg::A_NEXT_DIGIT: begin
                    cnt_next   = cnt_reg - 4'd1;
                    digit_next = 4'd0;
                end
                chlcd_pkg::A_LOAD_CNT: begin
                    cnt_next   = 4'd7;
                    final_next = 1'b0;
                end
                chlcd_pkg::A_FINAL_CNT: final_next = cnt_reg == 4'd0;
                chlcd_pkg::A_SHL4: begin
                    val_next = {val_reg[27:0], 4'd0};
                    cnt_next = cnt_reg - 4'd1;
                end
                chlcd_pkg::A_SHL1: begin
                    val_next = {val_reg[30:0], 1'b0};
                    cnt_next = cnt_reg - 4'd1;
                end
                chlcd_pkg::A_INIT_SETUP: begin
                    cnt_next       = 4'd0;
                    col_count_next = '0;
                    row_next       = 2'd0;
                end
                chlcd_pkg::A_INC_CNT: cnt_next = cnt_reg + 4'd1;
                chlcd_pkg::A_NEXTROW: begin
                    y_next = (row_reg == ROW_LAST) ? 2'd0 : row_reg + 2'd1;
                    x_next = '0;
                end
                chlcd_pkg::A_INCCOL: col_count_next = col_count_reg + 1'b1;
                default: begin
                end
            endcase
        end
    end

    // bus write assembly
    always_comb begin
        wr_req.rs = cw.rs;
        case (cw.bsel)
            chlcd_pkg::BS_CHAR:   wr_req.bus_byte = pch_reg;
            chlcd_pkg::BS_CURSOR: wr_req.bus_byte = chlcd_pkg::line_base(y_reg) + 8'(x_reg);
            chlcd_pkg::BS_CLEAR:  wr_req.bus_byte = chlcd_pkg::LCD_CLEAR;
            chlcd_pkg::BS_HOME:   wr_req.bus_byte = chlcd_pkg::LCD_HOME;
            chlcd_pkg::BS_INIT:   wr_req.bus_byte = chlcd_pkg::init_byte(cnt_reg);
            default:              wr_req.bus_byte = pch_reg;
        endcase
        case (cw.wsel)
            chlcd_pkg::WS_CHAR:   wr_req.settle_wait = chlcd_pkg::WAIT_CHAR;
            chlcd_pkg::WS_CURSOR: wr_req.settle_wait = chlcd_pkg::WAIT_CURSOR;
            chlcd_pkg::WS_CLEAR:  wr_req.settle_wait = chlcd_pkg::WAIT_CLEAR;
            chlcd_pkg::WS_INIT:   wr_req.settle_wait = chlcd_pkg::WAIT_INIT;
            default:              wr_req.settle_wait = chlcd_pkg::WAIT_CHAR;
        endcase
        case (cw.lsel)
            chlcd_pkg::LS_ZERO:  wr_req.last = 1'b0;
            chlcd_pkg::LS_ONE:   wr_req.last = 1'b1;
            chlcd_pkg::LS_FINAL: wr_req.last = final_reg;
            chlcd_pkg::LS_INIT:  wr_req.last = cnt_reg == INIT_END;
            default:             wr_req.last = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= chlcd_pkg::PC_IDLE;
            ret_reg       <= chlcd_pkg::PC_IDLE;
            col_count_reg <= '0;
            row_reg       <= 2'd0;
            digit_reg     <= 4'd0;
        end else begin
            pc_reg        <= pc_next;
            ret_reg       <= ret_next;
            col_count_reg <= col_count_next;
            row_reg       <= row_next;
            digit_reg     <= digit_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        char_reg    <= char_next;
        val_reg     <= val_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        cnt_reg     <= cnt_next;
        started_reg <= started_next;
        final_reg   <= final_next;
        pch_reg     <= pch_next;
    end

    chlcd_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (out_load),
        .req           (wr_req),
        .free          (out_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_reg_select  (m_reg_select),
        .m_bus_byte    (m_bus_byte),
        .m_settle_wait (m_settle_wait),
        .m_last        (m_last)
    );

    // checks
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_count_reg <= COLS_C)
        else $error("column count beyond line length");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, row_reg} < ROWS_C)
        else $error("row index beyond last row");

    a_char_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && wr_req.rs) |-> (col_count_reg < COLS_C))
        else $error("character written on a full line");

    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg != chlcd_pkg::PC_IDLE) |-> (digit_reg <= 4'd9))
        else $error("decimal digit out of range");

endmodule

`default_nettype wire

/* rtl/chlcd_out_stage.sv */
// ----------------------------------------------------------------------------
// chlcd_out_stage: result register of the LCD text engine
// Holds one bus write until the sink takes it; frees in the same cycle
// that the held transaction is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module chlcd_out_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             load,
    input  wire chlcd_pkg::wr_t   req,
    output logic                  free,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_reg_select,
    output logic [7:0]            m_bus_byte,
    output logic [11:0]           m_settle_wait,
    output logic                  m_last
);

    logic           valid_reg;
    logic           valid_next;
    chlcd_pkg::wr_t data_reg;

    assign free = !valid_reg || m_ready;

    // occupancy
    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= req;
        end
    end

    assign m_valid       = valid_reg;
    assign m_reg_select  = data_reg.rs;
    assign m_bus_byte    = data_reg.bus_byte;
    assign m_settle_wait = data_reg.settle_wait;
    assign m_last        = data_reg.last;

endmodule

`default_nettype wire
